// ===== hdl/dsc_pkg.sv =====
package dsc_pkg;

	// line store geometry
	localparam int MAX_ROW_PIXELS = 1024;
	localparam int COL_W = $clog2(MAX_ROW_PIXELS);
	localparam int ADDR_W = COL_W + 1;

	// register and counter widths
	localparam int SIZE_W = 11;
	localparam int ROW_W = 10;
	localparam int OCNT_W = 10;
	localparam int POS_W = 27;
	localparam int FRAC_BITS = 16;
	localparam int INT_W = POS_W - FRAC_BITS;
	localparam int CMP_W = ((COL_W > INT_W) ? COL_W : INT_W) + 1;
	localparam int PIX_W = 8;

	// limits
	localparam logic [SIZE_W-1:0] SIZE_LIMIT = SIZE_W'(1024);
	localparam logic [POS_W-1:0] ONE_FP = POS_W'(32'h0001_0000);
	localparam logic [POS_W-1:0] STEP_LIMIT = POS_W'(32'h0400_0000);

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 27;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_W = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_H = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_W = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_H = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_H_STEP = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_V_STEP = 3'd5;

	// taps and weights of one output pixel, decided when its last source pixel is taken
	typedef struct packed {
		logic                 due;
		logic [PIX_W-1:0]     bl;
		logic [PIX_W-1:0]     br;
		logic [FRAC_BITS-1:0] fx;
		logic [FRAC_BITS-1:0] fy;
		logic                 use_left;
		logic                 has_top;
		logic                 row_end;
		logic                 frame_end;
	} tap_t;

	// line store access for one cycle
	typedef struct packed {
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		logic [PIX_W-1:0]  wr_data;
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
	} mem_req_t;

endpackage

// ===== hdl/dsc_ifs.sv =====
interface dsc_pix_in_if;
	logic                      valid;
	logic                      ready;
	logic [dsc_pkg::PIX_W-1:0] luma;
	logic                      frame_start;
	modport source(output valid, luma, frame_start, input ready);
	modport sink(input valid, luma, frame_start, output ready);
endinterface

interface dsc_pix_out_if;
	logic                      valid;
	logic                      ready;
	logic [dsc_pkg::PIX_W-1:0] pixel;
	logic                      row_end;
	logic                      frame_end;
	modport source(output valid, pixel, row_end, frame_end, input ready);
	modport sink(input valid, pixel, row_end, frame_end, output ready);
endinterface

interface dsc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [dsc_pkg::CFG_IDX_W-1:0]  index;
	logic [dsc_pkg::CFG_DATA_W-1:0] wdata;
	modport source(output valid, index, wdata, input ready);
	modport sink(input valid, index, wdata, output ready);
endinterface

// ===== hdl/bilinear_image_downscaler.sv =====
// Streaming bilinear downscaler for 8-bit luma. Source pixels enter in raster
// order, one word per clock, and are never held back while the output side
// takes its words; an output pixel passes through the four blend stages and
// the output register after the source pixel that completes its lower-right
// tap. When the output stalls, these stages and the register fill, then input stops.
// The previous and current source rows live in one 2 x 1024 x 8 memory with
// one write and one registered read per clock; that single read port is what
// fetches the upper taps, the upper-left one being kept from the previous
// column. Line-store contents are undefined after reset and need no clearing
// pass. Configuration writes are taken every clock, are saturated to the
// legal range, and must only be made while no pixel is in flight.
module bilinear_image_downscaler (
	input  logic          clk,
	input  logic          arst_n,
	dsc_pix_in_if.sink    pix_in,
	dsc_pix_out_if.source pix_out,
	dsc_cfg_if.sink       cfg
);

	dsc_pkg::tap_t             tap;
	dsc_pkg::mem_req_t         mem_req;
	logic [dsc_pkg::PIX_W-1:0] rd_data;
	logic                      take_ok;
	logic                      acc;

	assign pix_in.ready = take_ok;
	assign acc          = pix_in.valid && take_ok;

	dsc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.luma        (pix_in.luma),
		.frame_start (pix_in.frame_start),
		.acc         (acc),
		.tap         (tap),
		.mem_req     (mem_req)
	);

	dsc_line_ram u_line_ram (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	dsc_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.tap     (tap),
		.acc     (acc),
		.rd_data (rd_data),
		.take_ok (take_ok),
		.pix_out (pix_out)
	);

endmodule

// ===== hdl/dsc_line_ram.sv =====
module dsc_line_ram (
	input  logic                      clk,
	input  dsc_pkg::mem_req_t         req,
	output logic [dsc_pkg::PIX_W-1:0] rd_data
);

	logic [dsc_pkg::PIX_W-1:0] mem [2*dsc_pkg::MAX_ROW_PIXELS];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end

endmodule

// ===== hdl/dsc_ctrl.sv =====
module dsc_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	dsc_cfg_if.sink                   cfg,
	input  logic [dsc_pkg::PIX_W-1:0] luma,
	input  logic                      frame_start,
	input  logic                      acc,
	output dsc_pkg::tap_t             tap,
	output dsc_pkg::mem_req_t         mem_req
);

	localparam int SW = dsc_pkg::SIZE_W;
	localparam int PW = dsc_pkg::POS_W;
	localparam int IW = dsc_pkg::INT_W;
	localparam int CW = dsc_pkg::COL_W;
	localparam int RW = dsc_pkg::ROW_W;
	localparam int OW = dsc_pkg::OCNT_W;
	localparam int MW = dsc_pkg::CMP_W;

	function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
			input logic [SW-1:0] hi);
		logic [SW-1:0] r;
		r = v;
		if (v == '0) r = SW'(1);
		else if (v > hi) r = hi;
		return r;
	endfunction

	function automatic logic [PW-1:0] clamp_step(input logic [PW-1:0] v);
		logic [PW-1:0] r;
		r = v;
		if (v < dsc_pkg::ONE_FP) r = dsc_pkg::ONE_FP;
		else if (v > dsc_pkg::STEP_LIMIT) r = dsc_pkg::STEP_LIMIT;
		return r;
	endfunction

	// registers, held saturated
	logic [SW-1:0] src_w_q, src_h_q, out_w_q, out_h_q;
	logic [PW-1:0] h_step_q, v_step_q;

	// frame state
	logic          bank_q;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [OW-1:0] ocol_q, orow_q;
	logic [PW-1:0] x_q, y_q;
	logic          done_q;
	logic [dsc_pkg::PIX_W-1:0] prev_q;

	// values seen by the current word, after a frame start
	logic [CW-1:0] col_e;
	logic [RW-1:0] row_e;
	logic [OW-1:0] ocol_e, orow_e;
	logic [PW-1:0] x_e, y_e;
	logic          done_e;

	logic [IW-1:0] sx0, sy0, sx1, sy1;
	logic [IW:0]   sx0p1, sy0p1;
	logic          due, use_left, has_top, rend, fend, last_col, last_row;

	logic          bank_n;
	logic [CW-1:0] col_n;
	logic [RW-1:0] row_n;
	logic [OW-1:0] ocol_n, orow_n;
	logic [PW-1:0] x_n, y_n;
	logic          done_n;

	assign cfg.ready = 1'b1;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q  <= SW'(640);
			src_h_q  <= SW'(480);
			out_w_q  <= SW'(296);
			out_h_q  <= SW'(256);
			h_step_q <= PW'(141699);
			v_step_q <= PW'(122880);
		end else if (cfg.valid) begin
			case (cfg.index)
				dsc_pkg::REG_SRC_W: begin
					src_w_q <= clamp_size(cfg.wdata[SW-1:0], SW'(dsc_pkg::MAX_ROW_PIXELS));
				end
				dsc_pkg::REG_SRC_H: begin
					src_h_q <= clamp_size(cfg.wdata[SW-1:0], dsc_pkg::SIZE_LIMIT);
				end
				dsc_pkg::REG_OUT_W: begin
					out_w_q <= clamp_size(cfg.wdata[SW-1:0], dsc_pkg::SIZE_LIMIT);
				end
				dsc_pkg::REG_OUT_H: begin
					out_h_q <= clamp_size(cfg.wdata[SW-1:0], dsc_pkg::SIZE_LIMIT);
				end
				dsc_pkg::REG_H_STEP: begin
					h_step_q <= clamp_step(cfg.wdata[PW-1:0]);
				end
				dsc_pkg::REG_V_STEP: begin
					v_step_q <= clamp_step(cfg.wdata[PW-1:0]);
				end
				default: begin
				end
			endcase
		end
	end

	// tap decision and next state
	always_comb begin
		col_e  = frame_start ? '0 : col_q;
		row_e  = frame_start ? '0 : row_q;
		ocol_e = frame_start ? '0 : ocol_q;
		orow_e = frame_start ? '0 : orow_q;
		x_e    = frame_start ? '0 : x_q;
		y_e    = frame_start ? '0 : y_q;
		done_e = frame_start ? 1'b0 : done_q;

		sx0   = x_e[PW-1:dsc_pkg::FRAC_BITS];
		sy0   = y_e[PW-1:dsc_pkg::FRAC_BITS];
		sx0p1 = {1'b0, sx0} + (IW+1)'(1);
		sy0p1 = {1'b0, sy0} + (IW+1)'(1);
		sx1   = (sx0p1 < (IW+1)'(src_w_q)) ? sx0p1[IW-1:0] : sx0;
		sy1   = (sy0p1 < (IW+1)'(src_h_q)) ? sy0p1[IW-1:0] : sy0;

		due      = !done_e && (MW'(sx1) == MW'(col_e)) && (MW'(sy1) == MW'(row_e));
		use_left = MW'(sx0) == MW'(col_e);
		has_top  = MW'(sy0) != MW'(row_e);
		rend     = (SW'(ocol_e) + SW'(1)) >= out_w_q;
		fend     = rend && ((SW'(orow_e) + SW'(1)) >= out_h_q);
		last_col = (MW'(col_e) + MW'(1)) >= MW'(src_w_q);
		last_row = (SW'(row_e) + SW'(1)) >= src_h_q;

		bank_n = bank_q;
		col_n  = col_e;
		row_n  = row_e;
		ocol_n = ocol_e;
		orow_n = orow_e;
		x_n    = x_e;
		y_n    = y_e;
		done_n = done_e;

		// output position advance
		if (due) begin
			if (rend) begin
				ocol_n = '0;
				x_n    = '0;
				if (fend) begin
					done_n = 1'b1;
				end else begin
					orow_n = orow_e + OW'(1);
					y_n    = y_e + v_step_q;
				end
			end else begin
				ocol_n = ocol_e + OW'(1);
				x_n    = x_e + h_step_q;
			end
		end

		// source position advance, frame wraps after its last pixel
		if (last_col) begin
			col_n  = '0;
			bank_n = ~bank_q;
			if (last_row) begin
				row_n  = '0;
				ocol_n = '0;
				orow_n = '0;
				x_n    = '0;
				y_n    = '0;
				done_n = 1'b0;
			end else begin
				row_n = row_e + RW'(1);
			end
		end else begin
			col_n = col_e + CW'(1);
		end
	end

	always_comb begin
		tap.due       = due;
		tap.bl        = use_left ? luma : prev_q;
		tap.br        = luma;
		tap.fx        = x_e[dsc_pkg::FRAC_BITS-1:0];
		tap.fy        = y_e[dsc_pkg::FRAC_BITS-1:0];
		tap.use_left  = use_left;
		tap.has_top   = has_top;
		tap.row_end   = rend;
		tap.frame_end = fend;

		// write this row's bank, read the row above at the same column
		mem_req.wr_en   = acc;
		mem_req.wr_addr = {bank_q, col_e};
		mem_req.wr_data = luma;
		mem_req.rd_en   = acc;
		mem_req.rd_addr = {~bank_q, col_e};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
			x_q    <= '0;
			y_q    <= '0;
			done_q <= 1'b0;
			prev_q <= '0;
		end else if (acc) begin
			bank_q <= bank_n;
			col_q  <= col_n;
			row_q  <= row_n;
			ocol_q <= ocol_n;
			orow_q <= orow_n;
			x_q    <= x_n;
			y_q    <= y_n;
			done_q <= done_n;
			prev_q <= luma;
		end
	end

endmodule

// ===== hdl/dsc_blend.sv =====
module dsc_blend (
	input  logic                      clk,
	input  logic                      arst_n,
	input  dsc_pkg::tap_t             tap,
	input  logic                      acc,
	input  logic [dsc_pkg::PIX_W-1:0] rd_data,
	output logic                      take_ok,
	dsc_pix_out_if.source             pix_out
);

	localparam int FB = dsc_pkg::FRAC_BITS;
	localparam int XW = dsc_pkg::PIX_W;
	localparam int PROD_W = XW + FB + 2;

	// upper-left pixel of the row above, kept from the previous word
	logic [XW-1:0] top_left_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4, ov_q;
	logic r1, r2, r3, r4, r_out;

	dsc_pkg::tap_t tap_s1;

	logic [XW-1:0] tl, tr;
	logic signed [XW:0]   dt_top, dt_bot;
	logic signed [FB:0]   fx_s;
	logic signed [PROD_W-1:0] pt, pb;

	logic [XW-1:0] tl_s2, bl_s2;
	logic signed [PROD_W-1:0] pt_s2, pb_s2;
	logic [FB-1:0] fy_s2;
	logic rend_s2, fend_s2;

	logic signed [PROD_W-1:0] sum_top, sum_bot;

	logic [XW-1:0] top_s3, bot_s3;
	logic [FB-1:0] fy_s3;
	logic rend_s3, fend_s3;

	logic signed [XW:0] dv;
	logic signed [FB:0] fy_s;
	logic signed [PROD_W-1:0] pv;

	logic [XW-1:0] top_s4;
	logic signed [PROD_W-1:0] pv_s4;
	logic rend_s4, fend_s4;

	logic signed [PROD_W-1:0] sum_pix;

	logic [XW-1:0] pix_q;
	logic rend_q, fend_q;

	// stage readiness, back to front
	assign r_out   = !ov_q || pix_out.ready;
	assign r4      = !v4_s4 || r_out;
	assign r3      = !v3_s3 || r4;
	assign r2      = !v2_s2 || r3;
	assign r1      = !v1_s1 || r2;
	assign take_ok = r1;

	always_ff @(posedge clk) begin
		if (acc) begin
			top_left_q <= rd_data;
		end
	end

	// s1: pick taps, horizontal products
	always_comb begin
		tr     = tap_s1.has_top ? rd_data : tap_s1.br;
		tl     = tap_s1.has_top ? (tap_s1.use_left ? rd_data : top_left_q) : tap_s1.bl;
		dt_top = $signed({1'b0, tr}) - $signed({1'b0, tl});
		dt_bot = $signed({1'b0, tap_s1.br}) - $signed({1'b0, tap_s1.bl});
		fx_s   = $signed({1'b0, tap_s1.fx});
		pt     = PROD_W'(dt_top) * PROD_W'(fx_s);
		pb     = PROD_W'(dt_bot) * PROD_W'(fx_s);
	end

	// s2: finish horizontal blends, truncate
	always_comb begin
		sum_top = $signed({2'b00, tl_s2, {FB{1'b0}}}) + pt_s2;
		sum_bot = $signed({2'b00, bl_s2, {FB{1'b0}}}) + pb_s2;
	end

	// s3: vertical product
	always_comb begin
		dv   = $signed({1'b0, bot_s3}) - $signed({1'b0, top_s3});
		fy_s = $signed({1'b0, fy_s3});
		pv   = PROD_W'(dv) * PROD_W'(fy_s);
	end

	// s4: finish vertical blend, truncate
	assign sum_pix = $signed({2'b00, top_s4, {FB{1'b0}}}) + pv_s4;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			ov_q  <= 1'b0;
		end else begin
			if (r1) v1_s1 <= acc && tap.due;
			if (r2) v2_s2 <= v1_s1;
			if (r3) v3_s3 <= v2_s2;
			if (r4) v4_s4 <= v3_s3;
			if (r_out) ov_q <= v4_s4;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (acc) begin
			tap_s1 <= tap;
		end
		if (v1_s1 && r2) begin
			tl_s2   <= tl;
			bl_s2   <= tap_s1.bl;
			pt_s2   <= pt;
			pb_s2   <= pb;
			fy_s2   <= tap_s1.fy;
			rend_s2 <= tap_s1.row_end;
			fend_s2 <= tap_s1.frame_end;
		end
		if (v2_s2 && r3) begin
			top_s3  <= sum_top[XW+FB-1:FB];
			bot_s3  <= sum_bot[XW+FB-1:FB];
			fy_s3   <= fy_s2;
			rend_s3 <= rend_s2;
			fend_s3 <= fend_s2;
		end
		if (v3_s3 && r4) begin
			top_s4  <= top_s3;
			pv_s4   <= pv;
			rend_s4 <= rend_s3;
			fend_s4 <= fend_s3;
		end
		if (v4_s4 && r_out) begin
			pix_q  <= sum_pix[XW+FB-1:FB];
			rend_q <= rend_s4;
			fend_q <= fend_s4;
		end
	end

	assign pix_out.valid     = ov_q;
	assign pix_out.pixel     = pix_q;
	assign pix_out.row_end   = rend_q;
	assign pix_out.frame_end = fend_q;

endmodule

// ===== hdl/dsc_checker.sv =====
module dsc_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_ready,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [dsc_pkg::PIX_W-1:0] out_pixel,
	input logic                      out_row_end,
	input logic                      out_frame_end,
	input logic                      cfg_ready
);

	// last pixel of a frame also closes its row
	a_frame_end_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_frame_end |-> out_row_end)
		else $error("frame_end without row_end");

	// with the output register empty nothing can block the input
	a_in_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// register port never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	// a stalled word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_pixel)
			&& $stable(out_row_end) && $stable(out_frame_end))
		else $error("output word changed while stalled");

endmodule

bind bilinear_image_downscaler dsc_checker u_dsc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_ready      (pix_in.ready),
	.out_valid     (pix_out.valid),
	.out_ready     (pix_out.ready),
	.out_pixel     (pix_out.pixel),
	.out_row_end   (pix_out.row_end),
	.out_frame_end (pix_out.frame_end),
	.cfg_ready     (cfg.ready)
);
